/* src/nfi_pkg.sv */
// ----------------------------------------------------------------------------
// nfi_pkg
// shared types, widths and saturation helpers for the interpolator
// ----------------------------------------------------------------------------
package nfi_pkg;

  localparam int DATA_W = 32;
  localparam int DVD_W  = 64;   // divider dividend and quotient width
  localparam int DVS_W  = 48;   // divider divisor width
  localparam int FACT_W = 32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_ZEROH = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // saturate a wide signed value to 32 bits, msb of result is the overflow flag
  function automatic logic [DATA_W:0] sat66(input logic signed [65:0] v);
    logic [DATA_W:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [DVD_W-1:0] abs64(input logic signed [DVD_W-1:0] v);
    logic [DVD_W-1:0] r;
    r = v[DVD_W-1] ? DVD_W'(-v) : DVD_W'(v);
    return r;
  endfunction

endpackage

/* src/nfi_cell.sv */
// ----------------------------------------------------------------------------
// nfi_cell
// one difference cell: holds an ordinate, steps to next-minus-own on command
// ----------------------------------------------------------------------------
module nfi_cell import nfi_pkg::*; (
  input  logic              clk,
  input  logic              load_en,
  input  logic [DATA_W-1:0] load_val,
  input  logic              step_en,
  input  logic [DATA_W-1:0] nbr_val,
  output logic [DATA_W-1:0] val,
  output logic              sat
);

  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W:0]   dif;

  always_comb begin
    dif = sat66(66'($signed(nbr_val)) - 66'($signed(val_r)));
    sat = step_en & dif[DATA_W];
    val_nxt = val_r;
    if (load_en) begin
      val_nxt = load_val;
    end else if (step_en) begin
      val_nxt = dif[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

/* src/nfi_div.sv */
// ----------------------------------------------------------------------------
// nfi_div
// restoring unsigned divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module nfi_div import nfi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

endmodule

/* src/newton_forward_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// newton_forward_interpolator_unit
// newton forward-difference interpolator, q16.16
// ----------------------------------------------------------------------------
// Load items (tuser 0) store one sample point each and are taken one per cycle
// whenever the block is idle; loads beyond MAX_POINTS are dropped. An evaluate
// item (tuser 1) returns one result and clears the stored point count. The
// ordinates sit in a row of difference cells that each step computes
// neighbour-minus-own, so cell 0 yields the k-th leading difference after k
// steps. One shared bit-serial divider forms p and every term, and the
// products are formed in the multiply states. Fewer than two points or zero
// spacing skip the divider and give a result straight from the check state.
// A result waiting on the output does not block further loads.
module newton_forward_interpolator_unit import nfi_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // x_coord [31:0], y_coord [63:32]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // y_result [31:0], status [33:32], zero fill
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_PDIV = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_TMUL = 4'd4;
  localparam logic [3:0] S_TDS  = 4'd5;
  localparam logic [3:0] S_TDIV = 4'd6;
  localparam logic [3:0] S_UMUL = 4'd7;
  localparam logic [3:0] S_USAT = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, k_r, k_nxt;
  logic        flag_r, flag_nxt;
  logic        neg_r, neg_nxt;
  logic signed [DATA_W-1:0] x0_r, x0_nxt, x1_r, x1_nxt, xq_r, xq_nxt;
  logic signed [DATA_W-1:0] p_r, p_nxt, u_r, u_nxt, acc_r, acc_nxt;
  logic [FACT_W-1:0] fact_r, fact_nxt;
  logic signed [65:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] res_y_r, res_y_nxt;
  logic [1:0]  res_st_r, res_st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     in_acc;
  logic [MAX_POINTS-1:0]    cell_load, cell_step, cell_sat;
  logic [DATA_W-1:0]        cell_val [MAX_POINTS];

  // helpers
  logic signed [32:0] h_s, dx_s;
  logic signed [63:0] num_s;
  logic [DATA_W:0]    sat_r;
  logic signed [48:0] term_s;
  logic signed [65:0] trunc_s;
  logic signed [33:0] f_s;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // ordinate cells, each one fed by its upper neighbour, the top cell by zero
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (i == MAX_POINTS - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    assign cell_load[i] = in_acc & ~in_tuser & (cnt_r == CW'(i));
    assign cell_step[i] = (state_r == S_DIFF) &
                          ((CW + 1)'(i) + (CW + 1)'(k_r) < (CW + 1)'(n_r));
    nfi_cell u_cell (
      .clk      (clk),
      .load_en  (cell_load[i]),
      .load_val (in_tdata[63:32]),
      .step_en  (cell_step[i]),
      .nbr_val  (nbr),
      .val      (cell_val[i]),
      .sat      (cell_sat[i])
    );
  end

  nfi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    flag_nxt   = flag_r;
    neg_nxt    = neg_r;
    x0_nxt     = x0_r;
    x1_nxt     = x1_r;
    xq_nxt     = xq_r;
    p_nxt      = p_r;
    u_nxt      = u_r;
    acc_nxt    = acc_r;
    fact_nxt   = fact_r;
    prod_nxt   = prod_r;
    res_y_nxt  = res_y_r;
    res_st_nxt = res_st_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    div_req    = '0;
    sat_r      = '0;
    term_s     = '0;
    trunc_s    = '0;
    f_s        = '0;

    h_s   = 33'(x1_r) - 33'(x0_r);
    dx_s  = 33'(xq_r) - 33'(x0_r);
    num_s = 64'(dx_s) <<< 16;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) begin
            if (cnt_r < CW'(MAX_POINTS)) begin
              if (cnt_r == '0) x0_nxt = in_tdata[31:0];
              if (cnt_r == CW'(1)) x1_nxt = in_tdata[31:0];
              cnt_nxt = cnt_r + 1'b1;
            end
          end else begin
            n_nxt     = cnt_r;
            cnt_nxt   = '0;
            xq_nxt    = in_tdata[31:0];
            flag_nxt  = 1'b0;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (n_r < CW'(2)) begin
          res_y_nxt  = '0;
          res_st_nxt = ST_FEW;
          state_nxt  = S_FIN;
        end else if (h_s == '0) begin
          res_y_nxt  = '0;
          res_st_nxt = ST_ZEROH;
          state_nxt  = S_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = abs64(num_s);
          div_req.divisor  = DVS_W'(abs64(64'(h_s)));
          neg_nxt   = num_s[63] ^ h_s[32];
          state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          sat_r = sat66(neg_r ? -66'(div_rsp.quotient) : 66'(div_rsp.quotient));
          flag_nxt  = flag_r | sat_r[DATA_W];
          p_nxt     = sat_r[DATA_W-1:0];
          u_nxt     = sat_r[DATA_W-1:0];
          acc_nxt   = cell_val[0];
          k_nxt     = CW'(1);
          fact_nxt  = FACT_W'(1);
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        // one difference step: after it cell 0 holds the k-th leading difference
        flag_nxt  = flag_r | (|cell_sat);
        fact_nxt  = FACT_W'(fact_r * FACT_W'(k_r));
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        prod_nxt  = 66'(u_r * $signed(cell_val[0]));
        state_nxt = S_TDS;
      end
      S_TDS: begin
        div_req.start    = 1'b1;
        div_req.dividend = abs64(prod_r[63:0]);
        div_req.divisor  = DVS_W'({fact_r, 16'h0000});
        neg_nxt   = prod_r[63];
        state_nxt = S_TDIV;
      end
      S_TDIV: begin
        if (div_rsp.done) begin
          term_s = neg_r ? -49'($signed({1'b0, div_rsp.quotient[47:0]}))
                         : 49'($signed({1'b0, div_rsp.quotient[47:0]}));
          sat_r  = sat66(66'(acc_r) + 66'(term_s));
          flag_nxt = flag_r | sat_r[DATA_W];
          acc_nxt  = sat_r[DATA_W-1:0];
          if ((CW + 1)'(k_r) + 1'b1 < (CW + 1)'(n_r)) begin
            state_nxt = S_UMUL;
          end else begin
            res_y_nxt  = sat_r[DATA_W-1:0];
            res_st_nxt = (flag_r | sat_r[DATA_W]) ? ST_SAT : ST_OK;
            state_nxt  = S_FIN;
          end
        end
      end
      S_UMUL: begin
        f_s       = 34'(p_r) - $signed({2'b00, 16'(k_r), 16'h0000});
        prod_nxt  = 66'(u_r * f_s);
        state_nxt = S_USAT;
      end
      S_USAT: begin
        // divide by 65536, truncating toward zero
        trunc_s = (prod_r + (prod_r[65] ? 66'sd65535 : 66'sd0)) >>> 16;
        sat_r   = sat66(trunc_s);
        flag_nxt  = flag_r | sat_r[DATA_W];
        u_nxt     = sat_r[DATA_W-1:0];
        k_nxt     = k_r + 1'b1;
        state_nxt = S_DIFF;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, res_st_r, res_y_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    flag_r     <= flag_nxt;
    neg_r      <= neg_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    xq_r       <= xq_nxt;
    p_r        <= p_nxt;
    u_r        <= u_nxt;
    acc_r      <= acc_nxt;
    fact_r     <= fact_nxt;
    prod_r     <= prod_nxt;
    res_y_r    <= res_y_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // an evaluate always clears the stored point count
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> cnt_r == '0)
    else $error("point count not cleared by evaluate");

  // the divider only runs while the sequencer waits for it
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r == S_PDIV || state_r == S_TDIV))
    else $error("divider busy outside a wait state");

  // difference steps stay below the point count
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIFF |-> (k_r < n_r && k_r != '0))
    else $error("difference step out of range");
`endif

endmodule
